FILE: sv/stks_pkg.sv
// shared types, constants and the entry ordering for the streaming top-k selector
// no dependencies; imported by every other file of the block
package stks_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_W = 5;
	localparam int WEIGHT_W = 32;
	localparam int KEY_W = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef struct packed {
		logic signed [WEIGHT_W-1:0] weight;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic replace;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic beats_head;
		entry_t head;
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	// strict (weight, key) order: weight signed, key unsigned
	function automatic logic entry_less(input entry_t a, input entry_t b);
		logic res;
		if (a.weight != b.weight) begin
			res = $signed(a.weight) < $signed(b.weight);
		end else begin
			res = a.key < b.key;
		end
		return res;
	endfunction

endpackage

FILE: sv/stks_if.sv
// request channels of the streaming top-k selector: item input and kept-entry output
// depends on stks_pkg for the field widths
interface stks_in_if
	import stks_pkg::*;
;
	logic valid;
	logic ready;
	logic signed [WEIGHT_W-1:0] item_weight;
	logic [KEY_W-1:0] item_key;
	logic end_of_set;

	modport source (output valid, item_weight, item_key, end_of_set, input ready);
	modport sink (input valid, item_weight, item_key, end_of_set, output ready);
	modport mon (input valid, ready, item_weight, item_key, end_of_set);
endinterface

interface stks_out_if
	import stks_pkg::*;
;
	logic valid;
	logic ready;
	logic [KEY_W-1:0] kept_key;
	logic signed [WEIGHT_W-1:0] kept_weight;
	logic final_entry;

	modport source (output valid, kept_key, kept_weight, final_entry, input ready);
	modport sink (input valid, kept_key, kept_weight, final_entry, output ready);
	modport mon (input valid, ready, kept_key, kept_weight, final_entry);
endinterface

FILE: sv/stks_dp.sv
// datapath: a sorted row of entry cells, lowest (weight, key) in cell 0
// depends on stks_pkg; driven by commands from stks_ctrl
module stks_dp
	import stks_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  entry_t  item,
	input  cmd_t    cmd,
	output status_t status
);

	entry_t cells_q [MAX_ENTRIES];
	entry_t cells_d [MAX_ENTRIES];
	entry_t up [MAX_ENTRIES];
	entry_t dn [MAX_ENTRIES];
	logic [CNT_W-1:0] count_q;
	logic [MAX_ENTRIES-1:0] lt;
	logic [CNT_W-1:0] pos;

	// every valid cell compares against the new item in parallel
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			lt[i] = (CNT_W'(i) < count_q) && entry_less(cells_q[i], item);
		end
	end

	// the row is sorted, so the lower-than bits form a prefix
	assign pos = CNT_W'($countones(lt));

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (i < MAX_ENTRIES - 1) begin
				up[i] = cells_q[i + 1];
			end else begin
				up[i] = cells_q[i];
			end
			if (i > 0) begin
				dn[i] = cells_q[i - 1];
			end else begin
				dn[i] = cells_q[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			cells_d[i] = cells_q[i];
			if (cmd.insert) begin
				if (CNT_W'(i) == pos) begin
					cells_d[i] = item;
				end else if (CNT_W'(i) > pos) begin
					cells_d[i] = dn[i];
				end
			end else if (cmd.replace) begin
				// drop the minimum in cell 0, slide the lower part down
				if (CNT_W'(i + 1) == pos) begin
					cells_d[i] = item;
				end else if (CNT_W'(i + 1) < pos) begin
					cells_d[i] = up[i];
				end
			end else if (cmd.pop) begin
				cells_d[i] = up[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			cells_q[i] <= cells_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign status.count = count_q;
	assign status.head = cells_q[0];
	assign status.beats_head = $signed(item.weight) > $signed(cells_q[0].weight);

endmodule

FILE: sv/stks_ctrl.sv
// controller: capacity register, accept/emit state machine, datapath commands
// depends on stks_pkg; pairs with stks_dp
module stks_ctrl
	import stks_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             capacity_we,
	input  logic [CAP_W-1:0] capacity_wdata,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	output logic             out_valid,
	output logic             out_final,
	input  logic             out_ready,
	input  status_t          status,
	output cmd_t             cmd
);

	state_t state_q;
	state_t state_d;
	logic [CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] cap_eff;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (capacity_we) begin
			capacity_q <= capacity_wdata;
		end
	end

	// saturate at the number of cells
	assign cap_eff = (32'(capacity_q) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
		: CNT_W'(capacity_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.count == '0) begin
					state_d = ST_IDLE;
				end else if (out_ready && status.count == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EMIT: out_valid = status.count != '0;
			default: begin
				in_ready = 1'b0;
				out_valid = 1'b0;
			end
		endcase
	end

	assign accept = in_valid && in_ready;
	assign out_final = status.count == CNT_W'(1);

	always_comb begin
		cmd.insert = accept && cap_eff != '0 && status.count < cap_eff;
		// full (or over a lowered capacity): only a strictly heavier item displaces the minimum
		cmd.replace = accept && cap_eff != '0 && status.count >= cap_eff
			&& status.count != '0 && status.beats_head;
		cmd.pop = out_valid && out_ready;
	end

endmodule

FILE: sv/streaming_top_k_selector.sv
// Streaming top-k selector. Keeps the `capacity` heaviest items (by weight) of a data set
// in a sorted row of 16 cells; capacity 0 keeps nothing and values above 16 act as 16.
// An item without end_of_set is accepted straight away, so such items stream at one per clock.
// An item with end_of_set is inserted in that same cycle and then the held entries leave on
// `kept` in ascending (weight, key) order, one per cycle while `kept.ready` is high, straight
// from the lowest cell; final_entry marks the last one. During that emission `items.ready`
// is low, and the block also passes through its emit state when a set ends with nothing held.
// Write capacity only while the block is idle.
// depends on stks_pkg, stks_if, stks_ctrl, stks_dp
module streaming_top_k_selector
	import stks_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             capacity_we,
	input  logic [CAP_W-1:0] capacity_wdata,
	stks_in_if.sink          items,
	stks_out_if.source       kept
);

	cmd_t cmd;
	status_t status;
	entry_t item;

	assign item.weight = items.item_weight;
	assign item.key = items.item_key;

	stks_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.capacity_we    (capacity_we),
		.capacity_wdata (capacity_wdata),
		.in_valid       (items.valid),
		.in_last        (items.end_of_set),
		.in_ready       (items.ready),
		.out_valid      (kept.valid),
		.out_final      (kept.final_entry),
		.out_ready      (kept.ready),
		.status         (status),
		.cmd            (cmd)
	);

	stks_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status)
	);

	assign kept.kept_key = status.head.key;
	assign kept.kept_weight = status.head.weight;

endmodule

FILE: sv/stks_chk.sv
// port-level checker for the streaming top-k selector, bound to the top level
// depends on stks_pkg and stks_if
module stks_chk
	import stks_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	stks_in_if.sink    items,
	stks_out_if.source kept
);

	// a stalled output request holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		kept.valid && !kept.ready |=> kept.valid && $stable(kept.kept_key)
			&& $stable(kept.kept_weight) && $stable(kept.final_entry))
		else $error("stalled kept request changed");

	// no input is taken while entries are being emitted
	assert property (@(posedge clk) disable iff (!arst_n)
		!(items.ready && kept.valid))
		else $error("input ready during emission");

	// an item that does not end the set causes no output
	assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready && !items.end_of_set |=> !kept.valid)
		else $error("output without end of set");

	// emitted entries rise in (weight, key) order
	assert property (@(posedge clk) disable iff (!arst_n)
		kept.valid && kept.ready && !kept.final_entry |=> kept.valid
			&& (($signed(kept.kept_weight) > $signed($past(kept.kept_weight)))
			|| (kept.kept_weight == $past(kept.kept_weight)
			&& kept.kept_key >= $past(kept.kept_key))))
		else $error("emission out of order");

	// the final entry closes the run
	assert property (@(posedge clk) disable iff (!arst_n)
		kept.valid && kept.ready && kept.final_entry |=> !kept.valid && items.ready)
		else $error("emission continued past final entry");

endmodule

bind streaming_top_k_selector stks_chk u_stks_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.items  (items),
	.kept   (kept)
);

FILE: test/streaming_top_k_selector_tb.sv
// testbench for the streaming top-k selector: random and directed item streams with
// per-set prediction of the kept entries, checked in order on the output channel
// depends on stks_pkg, stks_if and streaming_top_k_selector
`timescale 1ns / 1ps

module streaming_top_k_selector_tb;
	import stks_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef struct {
		entry_t ent;
		logic last;
	} kept_exp_t;

	// tracks the heaviest entries of the open set and the kept entries still owed
	class heaviest_tracker;
		entry_t held[MAX_ENTRIES];
		int unsigned held_n;
		logic [CAP_W-1:0] cap;
		kept_exp_t kept_due[$];
		int unsigned errors;

		function new();
			held_n = 0;
			cap = CAP_RESET;
			errors = 0;
		endfunction

		function bit lighter(entry_t a, entry_t b);
			if (a.weight != b.weight)
				return $signed(a.weight) < $signed(b.weight);
			return a.key < b.key;
		endfunction

		function int unsigned lightest_slot();
			int unsigned best;
			best = 0;
			for (int unsigned i = 1; i < held_n; i++)
				if (lighter(held[i], held[best]))
					best = i;
			return best;
		endfunction

		function void take_item(logic [WEIGHT_W-1:0] w, logic [KEY_W-1:0] k, logic eos);
			entry_t e;
			entry_t pool[$];
			int unsigned lim;
			int unsigned slot;
			int unsigned best;
			kept_exp_t x;
			lim = (cap > MAX_ENTRIES) ? MAX_ENTRIES : cap;
			e.weight = w;
			e.key = k;
			if (lim != 0) begin
				if (held_n < lim) begin
					held[held_n] = e;
					held_n++;
				end else if (held_n > 0) begin
					// full (or over a lowered capacity): only a strictly heavier item gets in
					slot = lightest_slot();
					if ($signed(w) > $signed(held[slot].weight))
						held[slot] = e;
				end
			end
			if (eos) begin
				for (int unsigned i = 0; i < held_n; i++)
					pool.push_back(held[i]);
				while (pool.size() > 0) begin
					best = 0;
					for (int unsigned i = 1; i < pool.size(); i++)
						if (lighter(pool[i], pool[best]))
							best = i;
					x.ent = pool[best];
					x.last = (pool.size() == 1);
					kept_due.push_back(x);
					pool.delete(best);
				end
				held_n = 0;
			end
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task match_kept(logic [KEY_W-1:0] k, logic [WEIGHT_W-1:0] w, logic fin);
			kept_exp_t x;
			if (kept_due.size() == 0) begin
				report_mismatch($sformatf("kept entry key %h weight %h with nothing pending", k, w));
				return;
			end
			x = kept_due.pop_front();
			if (k !== x.ent.key)
				report_mismatch($sformatf("kept_key %h, predicted %h", k, x.ent.key));
			if (w !== x.ent.weight)
				report_mismatch($sformatf("kept_weight %h, predicted %h", w, x.ent.weight));
			if (fin !== x.last)
				report_mismatch($sformatf("final_entry %b, predicted %b", fin, x.last));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic capacity_we;
	logic [CAP_W-1:0] capacity_wdata;
	int unsigned cycles = 0;
	int in_calm = 0;
	int out_calm = 0;
	heaviest_tracker model = new();

	stks_in_if items_ch();
	stks_out_if kept_ch();

	streaming_top_k_selector DUT (
		.clk(clk),
		.arst_n(arst_n),
		.capacity_we(capacity_we),
		.capacity_wdata(capacity_wdata),
		.items(items_ch.sink),
		.kept(kept_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (capacity_we)
				model.cap = capacity_wdata;
			if (items_ch.valid && items_ch.ready)
				model.take_item(items_ch.item_weight, items_ch.item_key, items_ch.end_of_set);
			if (kept_ch.valid && kept_ch.ready)
				model.match_kept(kept_ch.kept_key, kept_ch.kept_weight, kept_ch.final_entry);
		end
	end

	// random wait per request, with occasional stretches of back-to-back traffic
	function automatic int draw_gap(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	function automatic logic [WEIGHT_W-1:0] rand_weight();
		logic [WEIGHT_W-1:0] w;
		case ($urandom_range(0, 6))
			0: w = 32'h7fff_ffff;
			1: w = 32'h8000_0000;
			2: w = 32'($urandom_range(0, 8)) - 32'd4;
			3: w = {16'($urandom_range(0, 3)), 16'h0000};
			default: w = $urandom;
		endcase
		return w;
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		return ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
	endfunction

	// entered and left at a falling edge
	task automatic send_item(logic [WEIGHT_W-1:0] w, logic [KEY_W-1:0] k, logic eos);
		int gap;
		gap = draw_gap(in_calm);
		if (gap > 0) begin
			items_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		items_ch.item_weight <= w;
		items_ch.item_key <= k;
		items_ch.end_of_set <= eos;
		items_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!items_ch.ready);
		@(negedge clk);
	endtask

	// drain pending kept entries, then let the block go idle
	task automatic settle();
		items_ch.valid <= 1'b0;
		while (model.kept_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] v);
		capacity_wdata <= v;
		capacity_we <= 1'b1;
		@(negedge clk);
		capacity_we <= 1'b0;
	endtask

	initial begin
		int gap;
		kept_ch.ready = 1'b0;
		forever begin
			gap = draw_gap(out_calm);
			if (gap > 0) begin
				kept_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			kept_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!kept_ch.valid);
			@(negedge clk);
		end
	end

	initial begin
		logic [CAP_W-1:0] start_caps[6];
		logic [CAP_W-1:0] cap_v;
		int sent;
		int phase;
		int sets;
		int len;
		bit cut;
		start_caps = '{5'd31, 5'd17, 5'd2, 5'd0, 5'd16, 5'd1};
		items_ch.valid = 1'b0;
		items_ch.item_weight = '0;
		items_ch.item_key = '0;
		items_ch.end_of_set = 1'b0;
		capacity_we = 1'b0;
		capacity_wdata = '0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// extremes, equal weight and key twice, tie broken by key
		send_item(32'h7fff_ffff, 32'h0000_0000, 1'b0);
		send_item(32'h8000_0000, 32'hffff_ffff, 1'b0);
		send_item(32'h0000_0000, 32'd5, 1'b0);
		send_item(32'h0000_0000, 32'd5, 1'b0);
		send_item(32'h0000_0000, 32'd3, 1'b0);
		send_item(32'hffff_ffff, 32'd1, 1'b0);
		send_item(32'h0000_0001, 32'd2, 1'b1);

		// capacity zero keeps nothing, end of set with an empty store
		settle();
		write_capacity(5'd0);
		send_item(32'h0001_0000, 32'd7, 1'b0);
		send_item(32'h0002_0000, 32'd8, 1'b1);

		// capacity one: equal weight does not replace, heavier does
		settle();
		write_capacity(5'd1);
		send_item(32'h000a_0000, 32'd1, 1'b0);
		send_item(32'h000a_0000, 32'd2, 1'b0);
		send_item(32'h000b_0000, 32'd3, 1'b1);

		// capacity lowered below the held count in the middle of a set
		settle();
		write_capacity(5'd4);
		send_item(32'h0001_0000, 32'd11, 1'b0);
		send_item(32'h0002_0000, 32'd12, 1'b0);
		send_item(32'h0003_0000, 32'd13, 1'b0);
		send_item(32'h0004_0000, 32'd14, 1'b0);
		settle();
		write_capacity(5'd2);
		send_item(32'h0000_0000, 32'd15, 1'b0);
		send_item(32'h0009_0000, 32'd16, 1'b1);

		sent = 0;
		phase = 0;
		while (sent < 110) begin
			if (phase < 6)
				cap_v = start_caps[phase];
			else if ($urandom_range(0, 2) == 0)
				cap_v = $urandom_range(0, 31);
			else
				cap_v = $urandom_range(1, 16);
			settle();
			write_capacity(cap_v);
			sets = $urandom_range(1, 3);
			for (int s = 0; s < sets; s++) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 30) : $urandom_range(1, 12);
				// sometimes leave the set open across the next capacity change
				cut = (s == sets - 1) && ($urandom_range(0, 3) == 0);
				for (int j = 0; j < len; j++) begin
					send_item(rand_weight(), rand_key(), (j == len - 1) && !cut);
					sent++;
				end
			end
			phase++;
		end
		send_item(rand_weight(), rand_key(), 1'b1);

		items_ch.valid <= 1'b0;
		while (model.kept_due.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		if (model.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
sv/stks_pkg.sv
sv/stks_if.sv
sv/stks_dp.sv
sv/stks_ctrl.sv
sv/streaming_top_k_selector.sv
sv/stks_chk.sv
test/streaming_top_k_selector_tb.sv
